[hdl/lpt_pkg.sv]
// ----------------------------------------------------------------------------
// lpt_pkg - shared definitions for the LRU page tracker
// Default sizes, configuration register width and reset value, and the
// control bundle broadcast from the top level to every tracker cell.
// ----------------------------------------------------------------------------
package lpt_pkg;

    // Default geometry
    localparam int LPT_ENTRIES     = 16;
    localparam int LPT_PAGE_BITS   = 16;
    localparam int LPT_ENTRIES_MAX = 256;

    // Stream field widths (fixed by the interface)
    localparam int LPT_PAGE_W = 16;   // page_number / evicted_page
    localparam int LPT_OCC_W  = 5;    // occupancy
    localparam int LPT_OUT_W  = 24;   // 23 payload bits, padded to 3 bytes

    // Capacity register
    localparam int              LPT_CAP_W     = 5;
    localparam logic [4:0]      LPT_CAP_RESET = 5'd16;

    // Count width wide enough for the largest supported chain
    localparam int LPT_CNT_W = $clog2(LPT_ENTRIES_MAX + 1);

    // Control broadcast to the cells during an update cycle
    typedef struct packed {
        logic                 upd;      // update cycle: cells shift/refresh
        logic                 hit;      // reference hit somewhere in the chain
        logic [LPT_CNT_W-1:0] cnt_old;  // resident count before this reference
        logic [LPT_CNT_W-1:0] cnt_ev;   // count after an eviction, if any
        logic [LPT_CNT_W-1:0] cnt_new;  // resident count after this reference
    } t_cell_ctl;

endpackage

[hdl/lpt_cell.sv]
// ----------------------------------------------------------------------------
// lpt_cell - one recency slot of the LRU page tracker
// Holds one tag and its valid bit, compares against the referenced page,
// passes the match and victim chains on, and takes its neighbor's tag on
// an update cycle when the recency order moves past it.
// ----------------------------------------------------------------------------
module lpt_cell
    import lpt_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = LPT_PAGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [PAGE_BITS-1:0] i_prev_tag,  // tag of the more recent neighbor
    input  logic                 i_seen,      // match in a more recent slot
    input  logic [PAGE_BITS-1:0] i_victim,
    output logic [PAGE_BITS-1:0] o_tag,
    output logic                 o_seen,
    output logic [PAGE_BITS-1:0] o_victim
);

    localparam logic [LPT_CNT_W-1:0] IDX_C    = LPT_CNT_W'(IDX);
    localparam logic [LPT_CNT_W-1:0] IDX_P1_C = LPT_CNT_W'(IDX + 1);

    logic [PAGE_BITS-1:0] r_tag;
    logic                 r_valid;
    logic                 w_match;
    logic                 w_shift;

    assign w_match  = r_valid && (r_tag == i_page);
    assign o_seen   = i_seen | w_match;
    assign o_tag    = r_tag;
    // the least recent valid slot sits at index cnt_old-1
    assign o_victim = i_victim | ((i_ctl.cnt_old == IDX_P1_C) ? r_tag : '0);

    // hit: slots up to and including the hit slot move down
    // miss: slots up to the (post-eviction) count move down
    assign w_shift = i_ctl.hit ? !i_seen : (IDX_C <= i_ctl.cnt_ev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.upd) begin
            r_valid <= (IDX_C < i_ctl.cnt_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && w_shift) begin
            r_tag <= i_prev_tag;
        end
    end

endmodule

[hdl/lru_page_tracker.sv]
// ----------------------------------------------------------------------------
// lru_page_tracker - fully associative LRU page tracker
// A row of ENTRIES cells kept in recency order reports hit, eviction and
// occupancy for each page reference.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one page reference per transfer (page_number in tdata).
//   m_axis returns one result per reference: hit, evicted_valid,
//   evicted_page (zero when nothing left) and the occupancy after it.
//   i_cfg_we/i_cfg_wdata write the capacity register (reset 16); 0 acts as 1
//   and values above ENTRIES act as ENTRIES. Write it only while idle.
// Timing:
//   A reference is latched on its transfer; the next cycle every cell
//   compares in parallel, the row shifts and the result is registered.
//   m_axis_tvalid rises once that result is registered; no new reference
//   is accepted while one is in that compare-and-shift cycle.
// Reset (synchronous, active low) empties the store and sets capacity to 16.
// Stalls: the result waits in the output register while m_axis_tready is
// low; s_axis_tready stays low until that register is free or being taken.
// ----------------------------------------------------------------------------
module lru_page_tracker
    import lpt_pkg::*;
#(
    parameter int ENTRIES   = LPT_ENTRIES,
    parameter int PAGE_BITS = LPT_PAGE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // capacity register
    input  logic                  i_cfg_we,
    input  logic [LPT_CAP_W-1:0]  i_cfg_wdata,
    // page references
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [LPT_PAGE_W-1:0] s_axis_tdata,  // [15:0] page_number
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] hit, [1] evicted_valid, [17:2] evicted_page, [22:18] occupancy,
    // [23] zero
    output logic [LPT_OUT_W-1:0]  m_axis_tdata
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > LPT_CAP_W) ? CNT_W : LPT_CAP_W;

    // control
    logic                  r_busy;
    logic                  r_out_valid;
    logic [LPT_CAP_W-1:0]  r_capacity;
    logic [CNT_W-1:0]      r_count;
    // payload
    logic [PAGE_BITS-1:0]  r_page;
    logic [LPT_OUT_W-1:0]  r_out_data;

    logic                  w_in_xfer;
    logic                  w_hit;
    logic                  w_evict;
    logic [CMP_W-1:0]      w_cap_sat;
    logic [CNT_W-1:0]      n_count_ev;
    logic [CNT_W-1:0]      n_count;
    logic [PAGE_BITS-1:0]  w_victim;
    logic [LPT_OUT_W-1:0]  n_out_data;
    t_cell_ctl             w_ctl;

    // chain links: index i feeds cell i
    logic [PAGE_BITS-1:0]  w_tag_link    [ENTRIES];
    logic                  w_seen_link   [ENTRIES+1];
    logic [PAGE_BITS-1:0]  w_victim_link [ENTRIES+1];

    // one reference in flight; accept once the output slot will be free
    assign s_axis_tready = !r_busy && (!r_out_valid || m_axis_tready);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---- cell row ----
    assign w_tag_link[0]    = r_page;     // new page enters at the MRU end
    assign w_seen_link[0]   = 1'b0;
    assign w_victim_link[0] = '0;

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        if (gi < ENTRIES - 1) begin : g_mid
            lpt_cell #(
                .IDX       (gi),
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_page     (r_page),
                .i_prev_tag (w_tag_link[gi]),
                .i_seen     (w_seen_link[gi]),
                .i_victim   (w_victim_link[gi]),
                .o_tag      (w_tag_link[gi+1]),
                .o_seen     (w_seen_link[gi+1]),
                .o_victim   (w_victim_link[gi+1])
            );
        end else begin : g_last
            // LRU end: its tag only leaves through the victim chain
            lpt_cell #(
                .IDX       (gi),
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_page     (r_page),
                .i_prev_tag (w_tag_link[gi]),
                .i_seen     (w_seen_link[gi]),
                .i_victim   (w_victim_link[gi]),
                .o_tag      (),
                .o_seen     (w_seen_link[gi+1]),
                .o_victim   (w_victim_link[gi+1])
            );
        end
    end

    assign w_hit    = w_seen_link[ENTRIES];
    assign w_victim = w_victim_link[ENTRIES];

    // ---- replacement decision ----
    always_comb begin
        // clamp capacity to 1..ENTRIES
        priority if (r_capacity == '0) begin
            w_cap_sat = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            w_cap_sat = CMP_W'(ENTRIES);
        end else begin
            w_cap_sat = CMP_W'(r_capacity);
        end

        w_evict = !w_hit && (CMP_W'(r_count) >= w_cap_sat) && (r_count != '0);

        n_count_ev = w_evict ? (r_count - CNT_W'(1)) : r_count;

        if (w_hit) begin
            n_count = r_count;
        end else if (n_count_ev == CNT_W'(ENTRIES)) begin
            n_count = n_count_ev;
        end else begin
            n_count = n_count_ev + CNT_W'(1);
        end

        w_ctl.upd     = r_busy;
        w_ctl.hit     = w_hit;
        w_ctl.cnt_old = LPT_CNT_W'(r_count);
        w_ctl.cnt_ev  = LPT_CNT_W'(n_count_ev);
        w_ctl.cnt_new = LPT_CNT_W'(n_count);

        n_out_data        = '0;
        n_out_data[0]     = w_hit;
        n_out_data[1]     = w_evict;
        n_out_data[17:2]  = w_evict ? LPT_PAGE_W'(w_victim) : '0;
        n_out_data[22:18] = LPT_OCC_W'(n_count);
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= LPT_CAP_RESET;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_page <= PAGE_BITS'(s_axis_tdata);
        end
        if (r_busy) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[hdl/lpt_checker.sv]
// ----------------------------------------------------------------------------
// lpt_checker - port-level checks for the LRU page tracker
// Watches the stream ports for ordering, result consistency and occupancy
// bounds; bound onto every lru_page_tracker instance.
// ----------------------------------------------------------------------------
module lpt_port_checks
    import lpt_pkg::*;
#(
    parameter int ENTRIES = LPT_ENTRIES
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [LPT_OUT_W-1:0]  m_axis_tdata
);

    // occupancy field wraps once the row holds more than it can show
    localparam bit OCC_WRAPS = (ENTRIES >= (1 << LPT_OCC_W));
    localparam int OCC_LIM   = OCC_WRAPS ? ((1 << LPT_OCC_W) - 1) : ENTRIES;
    localparam logic [LPT_OCC_W-1:0] OCC_MAX = LPT_OCC_W'(OCC_LIM);

    // a stalled result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one reference at a time: ready drops after a transfer, and the result follows
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 m_axis_tvalid)
        else $error("reference not processed in two cycles");

    // a hit never evicts, and without an eviction the page field is zero
    a_evict_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                          (m_axis_tdata[1] || (m_axis_tdata[17:2] == '0)))
        else $error("inconsistent eviction report");

    // occupancy within the store and, unless the field wraps, never zero after a reference
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:18] <= OCC_MAX) &&
                          (OCC_WRAPS || (m_axis_tdata[22:18] != '0)))
        else $error("occupancy out of range");

endmodule

bind lru_page_tracker lpt_port_checks #(
    .ENTRIES (ENTRIES)
) u_lpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/lpt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpt_checker - result checker for the LRU page tracker
// Watches the capacity port and both stream channels, keeps its own recency
// list of resident pages, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module lpt_checker
    import lpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LPT_CAP_W-1:0]  i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [LPT_PAGE_W-1:0] i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [LPT_OUT_W-1:0]  i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_hits,
    output int                    o_evictions
);

    typedef struct {
        logic                  hit;
        logic                  evicted;
        logic [LPT_PAGE_W-1:0] victim;
        logic [LPT_OCC_W-1:0]  occupancy;
    } t_lru_outcome;

    logic [LPT_PAGE_W-1:0] page_list [LPT_ENTRIES];  // slot 0 most recent
    int                    resident;
    logic [LPT_CAP_W-1:0]  capacity;
    t_lru_outcome          outcome_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_hits       = 0;
        o_evictions  = 0;
        resident     = 0;
        capacity     = LPT_CAP_RESET;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 30)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Applies one reference to the recency list and returns what it causes.
    function automatic t_lru_outcome lru_reference(input logic [LPT_PAGE_W-1:0] page);
        t_lru_outcome r;
        int           pos;
        int           lim;
        r.hit     = 1'b0;
        r.evicted = 1'b0;
        r.victim  = '0;
        pos       = -1;
        // 0 acts as 1, anything above the row size acts as the row size
        lim = (capacity == 0) ? 1 : ((capacity > LPT_ENTRIES) ? LPT_ENTRIES : capacity);
        for (int i = 0; i < resident; i++)
            if (pos < 0 && page_list[i] == page)
                pos = i;
        if (pos >= 0) begin
            r.hit = 1'b1;
            for (int i = pos; i > 0; i--)
                page_list[i] = page_list[i-1];
        end else begin
            // at or above capacity: drop only the least recent page
            if (resident >= lim && resident > 0) begin
                r.evicted = 1'b1;
                r.victim  = page_list[resident-1];
                resident--;
            end
            for (int i = resident; i > 0; i--)
                if (i < LPT_ENTRIES)
                    page_list[i] = page_list[i-1];
            if (resident < LPT_ENTRIES)
                resident++;
        end
        page_list[0] = page;
        r.occupancy  = resident[LPT_OCC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lru_outcome want;
        if (!i_rst_n) begin
            resident = 0;
            capacity = LPT_CAP_RESET;
            outcome_q.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                want = lru_reference(i_s_tdata);
                outcome_q.push_back(want);
                if (want.hit)
                    o_hits++;
                if (want.evicted)
                    o_evictions++;
            end
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, tdata %h",
                                              i_m_tdata));
                end else begin
                    want = outcome_q.pop_front();
                    if (i_m_tdata[0] !== want.hit)
                        report_mismatch($sformatf("hit %b, expected %b",
                                                  i_m_tdata[0], want.hit));
                    if (i_m_tdata[1] !== want.evicted)
                        report_mismatch($sformatf("evicted_valid %b, expected %b",
                                                  i_m_tdata[1], want.evicted));
                    if (i_m_tdata[17:2] !== want.victim)
                        report_mismatch($sformatf("evicted_page %h, expected %h",
                                                  i_m_tdata[17:2], want.victim));
                    if (i_m_tdata[22:18] !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  i_m_tdata[22:18], want.occupancy));
                    if (i_m_tdata[23] !== 1'b0)
                        report_mismatch("pad bit of result not zero");
                end
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

[bench/lru_page_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_tracker_tb - testbench top for the LRU page tracker
// Drives page references with random gaps and result back-pressure, steps
// the capacity register through its extremes between phases, and leaves all
// prediction and comparison to lpt_checker.
// ----------------------------------------------------------------------------
module lru_page_tracker_tb;
    import lpt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [LPT_CAP_W-1:0]  i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [LPT_PAGE_W-1:0] s_axis_tdata  = '0;   // [15:0] page_number
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] hit, [1] evicted_valid, [17:2] evicted_page, [22:18] occupancy
    logic [LPT_OUT_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int results;
    int hits;
    int evictions;
    int cap_writes = 0;

    // no random idling on either side while set
    logic quiet = 1'b0;

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    lru_page_tracker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lpt_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_hits       (hits),
        .o_evictions  (evictions)
    );

    // Result side back-pressure: ready is low about 28 percent of the time.
    always @(negedge i_clk)
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 28);

    // One page reference transfer. Called at a falling edge; returns at the
    // falling edge after the transfer. Valid stays high between back-to-back
    // calls, so it is only lowered inside an idle gap.
    task automatic push_ref(input logic [LPT_PAGE_W-1:0] pg);
        while (!quiet && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pg;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result. One result per
    // reference, so the block is idle once the checker has nothing pending.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Capacity write, only with the block idle.
    task automatic set_capacity(input logic [LPT_CAP_W-1:0] cap);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // Random phase: most references come from a small working set sized at or a
    // little above the effective capacity so hits and evictions both happen;
    // the rest are full-range pages.
    task automatic run_phase(input logic [LPT_CAP_W-1:0] cap, input int n_refs);
        logic [LPT_PAGE_W-1:0] work_set [24];
        int                    set_n;
        int                    eff;
        logic [LPT_PAGE_W-1:0] pg;
        set_capacity(cap);
        eff   = (cap == 0) ? 1 : ((cap > LPT_ENTRIES) ? LPT_ENTRIES : cap);
        set_n = eff + $urandom_range(0, 4);
        for (int i = 0; i < set_n; i++)
            work_set[i] = LPT_PAGE_W'($urandom);
        for (int k = 0; k < n_refs; k++) begin
            if ($urandom_range(0, 99) < 80)
                pg = work_set[$urandom_range(0, set_n - 1)];
            else
                pg = LPT_PAGE_W'($urandom);
            push_ref(pg);
        end
    endtask

    initial begin
        logic [LPT_CAP_W-1:0] caps [10] = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd16,
                                            5'd7, 5'd17, 5'd3, 5'd12, 5'd5};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset capacity of 16. Extremes of the page field first.
        push_ref(16'h0000);
        push_ref(16'hFFFF);
        push_ref(16'hAAAA);
        push_ref(16'h5555);
        push_ref(16'h0000);     // hit on the least recent slot
        push_ref(16'hFFFF);     // hit on the least recent slot again
        push_ref(16'hFFFF);     // hit on the most recent slot
        for (int k = 1; k <= 12; k++)
            push_ref(k[15:0]);  // fills the row to 16
        push_ref(16'h8000);     // miss at full row: evicts 0xAAAA
        push_ref(16'hAAAA);     // evicted page comes back, evicts 0x5555

        // Capacity dropped below occupancy: a miss evicts one and inserts
        // one, a hit evicts nothing.
        set_capacity(5'd4);
        push_ref(16'h1234);
        push_ref(16'h8000);

        // Random phases; 0 and 31 exercise the clamp at both ends, and
        // lowering after a full row keeps occupancy above capacity.
        foreach (caps[i]) begin
            quiet <= (i == 5);
            run_phase(caps[i], 170);
        end
        quiet <= 1'b0;

        drain();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d page references over %0d capacity settings,",
                 results, cap_writes + 1);
        $display("with %0d hits and %0d evictions.", hits, evictions);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
